FILE: hw/rtl/gbfs_pkg.sv
// Shared constants and types of the grid breadth-first search unit.
package gbfs_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int SIDE_W     = $clog2(MAX_SIDE);
  localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
  localparam int IDX_W      = $clog2(CELL_COUNT);
  localparam int CNT_W      = IDX_W + 1;
  localparam int PROD_W     = 2 * SIDE_W + 2;
  localparam int QUEUE_W    = 2 * SIDE_W + IDX_W;

  localparam int CFG_SIDE_W = 7;
  localparam int LIMIT_W    = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int PATH_W     = 12;
  localparam int STATUS_W   = 2;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_SIDE_W-1:0] RESET_COLUMNS = CFG_SIDE_W'(64);
  localparam logic [CFG_SIDE_W-1:0] RESET_ROWS    = CFG_SIDE_W'(64);
  localparam logic [LIMIT_W-1:0]    RESET_LIMIT   = LIMIT_W'(60);

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WALL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START = 2'd2;
  localparam logic [KIND_W-1:0] KIND_GOAL  = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_FOUND   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_UNREACH = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FAR     = 2'd2;

  // cell map entry: bit 1 visited, bit 0 wall
  localparam int CELL_W    = 2;
  localparam int CELL_WALL = 0;
  localparam int CELL_VIS  = 1;

  typedef enum logic [1:0] {
    DIR_ROW_INC = 2'd0,
    DIR_ROW_DEC = 2'd1,
    DIR_COL_INC = 2'd2,
    DIR_COL_DEC = 2'd3
  } dir_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_DIVIDE = 8'b0000_0100,
    S_POP    = 8'b0000_1000,
    S_QWAIT  = 8'b0001_0000,
    S_NBR    = 8'b0010_0000,
    S_NCHK   = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  function automatic logic [SIDE_W:0] clamp_side(input logic [CFG_SIDE_W-1:0] v);
    logic [SIDE_W:0] res;
    if (v == '0) begin
      res = (SIDE_W+1)'(1);
    end else if (32'(v) > MAX_SIDE) begin
      res = (SIDE_W+1)'(MAX_SIDE);
    end else begin
      res = (SIDE_W+1)'(v);
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/gbfs_ram.sv
// Generic simple dual-port RAM with registered read.
module gbfs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/grid_bfs_shortest_path_unit.sv
// Grid shortest path unit: cells stream in one per cycle in row-major order and are
// written to a cell map RAM (wall bit plus visited bit, the visited bit cleared as each
// cell loads, so no clearing pass is needed). The item with tlast set starts a
// four-neighbor breadth-first search from start to goal over a queue RAM; one result
// follows (distance and status). The search first turns the start index into row and
// column by repeated subtraction, then dequeues cells and checks the four neighbors of
// each in turn; every in-grid neighbor costs one read of the single cell map read port.
// Input is not taken during a search.
module grid_bfs_shortest_path_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gbfs_pkg::IN_DATA_W-1:0]    in_tdata,   // [1:0] cell_kind
  input  logic                              in_tlast,   // last_cell
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gbfs_pkg::OUT_DATA_W-1:0]   out_tdata,  // [11:0] path_distance, [13:12] search_status
  input  logic                              cfg_wr_en,
  input  logic [gbfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbfs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SW = gbfs_pkg::SIDE_W;
  localparam int IW = gbfs_pkg::IDX_W;
  localparam int CW = gbfs_pkg::CNT_W;
  localparam int PW = gbfs_pkg::PROD_W;

  gbfs_pkg::state_t state_r, state_nxt;
  gbfs_pkg::dir_t   dir_r, dir_nxt;

  logic [gbfs_pkg::CFG_SIDE_W-1:0] grid_columns_r, grid_rows_r;
  logic [gbfs_pkg::LIMIT_W-1:0]    distance_limit_r;

  logic [CW-1:0] load_pos_r, load_pos_nxt;
  logic          start_v_r, start_v_nxt, goal_v_r, goal_v_nxt;
  logic [IW-1:0] start_idx_r, start_idx_nxt, goal_idx_r, goal_idx_nxt;
  logic [IW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] qrow_r, qrow_nxt;
  logic [SW-1:0] cur_row_r, cur_row_nxt, cur_col_r, cur_col_nxt;
  logic [SW-1:0] nrow_r, nrow_nxt, ncol_r, ncol_nxt;
  logic [CW-1:0] dist_r, dist_nxt;
  logic [IW-1:0] nxt_r, nxt_nxt;
  logic [CW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic          found_r, found_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [gbfs_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [SW:0] cols_c, rows_c;
  logic [PW-1:0] total_w;

  logic                          cell_we;
  logic [IW-1:0]                 cell_waddr, cell_raddr;
  logic [gbfs_pkg::CELL_W-1:0]   cell_wdata, cell_q;
  logic                          q_we;
  logic [gbfs_pkg::QUEUE_W-1:0]  q_wdata, q_q;

  logic          nb_ok;
  logic [SW-1:0] nb_row, nb_col;
  logic [SW:0]   row_up, col_up;
  logic [PW-1:0] nb_idx_w;

  logic [gbfs_pkg::KIND_W-1:0]   kind;
  logic [gbfs_pkg::PATH_W-1:0]   path_sat;
  logic [gbfs_pkg::STATUS_W-1:0] found_stat;

  gbfs_ram #(.WIDTH(gbfs_pkg::CELL_W), .DEPTH(gbfs_pkg::CELL_COUNT)) u_cell_ram (
    .clk     (clk),
    .wr_en   (cell_we),
    .wr_addr (cell_waddr),
    .wr_data (cell_wdata),
    .rd_addr (cell_raddr),
    .rd_data (cell_q)
  );

  gbfs_ram #(.WIDTH(gbfs_pkg::QUEUE_W), .DEPTH(gbfs_pkg::CELL_COUNT)) u_queue_ram (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (tail_r[IW-1:0]),
    .wr_data (q_wdata),
    .rd_addr (head_r[IW-1:0]),
    .rd_data (q_q)
  );

  assign cols_c  = gbfs_pkg::clamp_side(grid_columns_r);
  assign rows_c  = gbfs_pkg::clamp_side(grid_rows_r);
  assign total_w = PW'(rows_c) * PW'(cols_c);
  assign kind    = in_tdata[gbfs_pkg::KIND_W-1:0];

  assign in_tready  = (state_r == gbfs_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // neighbor of the current cell in direction dir_r
  assign row_up = {1'b0, cur_row_r} + (SW+1)'(1);
  assign col_up = {1'b0, cur_col_r} + (SW+1)'(1);

  always_comb begin
    nb_ok  = 1'b0;
    nb_row = cur_row_r;
    nb_col = cur_col_r;
    unique case (dir_r)
      gbfs_pkg::DIR_ROW_INC: begin
        nb_ok  = row_up < rows_c;
        nb_row = row_up[SW-1:0];
      end
      gbfs_pkg::DIR_ROW_DEC: begin
        nb_ok  = cur_row_r != '0;
        nb_row = cur_row_r - SW'(1);
      end
      gbfs_pkg::DIR_COL_INC: begin
        nb_ok  = col_up < cols_c;
        nb_col = col_up[SW-1:0];
      end
      gbfs_pkg::DIR_COL_DEC: begin
        nb_ok  = cur_col_r != '0;
        nb_col = cur_col_r - SW'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign nb_idx_w   = PW'(nb_row) * PW'(cols_c) + PW'(nb_col);
  assign cell_raddr = nb_idx_w[IW-1:0];

  assign path_sat   = (32'(dist_r) > 32'({gbfs_pkg::PATH_W{1'b1}})) ?
                      {gbfs_pkg::PATH_W{1'b1}} : gbfs_pkg::PATH_W'(dist_r);
  assign found_stat = (32'(dist_r) >= 32'(distance_limit_r)) ?
                      gbfs_pkg::STAT_FAR : gbfs_pkg::STAT_FOUND;

  always_comb begin
    state_nxt     = state_r;
    dir_nxt       = dir_r;
    load_pos_nxt  = load_pos_r;
    start_v_nxt   = start_v_r;
    goal_v_nxt    = goal_v_r;
    start_idx_nxt = start_idx_r;
    goal_idx_nxt  = goal_idx_r;
    rem_nxt       = rem_r;
    qrow_nxt      = qrow_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    nrow_nxt      = nrow_r;
    ncol_nxt      = ncol_r;
    dist_nxt      = dist_r;
    nxt_nxt       = nxt_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    cell_we       = 1'b0;
    cell_waddr    = load_pos_r[IW-1:0];
    cell_wdata    = '0;
    q_we          = 1'b0;
    q_wdata       = {IW'(0), cur_col_r, cur_row_r};

    unique case (state_r)
      gbfs_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (PW'(load_pos_r) < total_w) begin
            cell_we    = 1'b1;
            cell_wdata = {1'b0, kind == gbfs_pkg::KIND_WALL};
            if (kind == gbfs_pkg::KIND_START) begin
              start_v_nxt   = 1'b1;
              start_idx_nxt = load_pos_r[IW-1:0];
            end
            if (kind == gbfs_pkg::KIND_GOAL) begin
              goal_v_nxt   = 1'b1;
              goal_idx_nxt = load_pos_r[IW-1:0];
            end
            load_pos_nxt = load_pos_r + CW'(1);
          end
          if (in_tlast) begin
            state_nxt = gbfs_pkg::S_CHECK;
          end
        end
      end
      gbfs_pkg::S_CHECK: begin
        found_nxt = 1'b0;
        head_nxt  = '0;
        tail_nxt  = '0;
        rem_nxt   = start_idx_r;
        qrow_nxt  = '0;
        if (!start_v_r || !goal_v_r || PW'(start_idx_r) >= total_w ||
            PW'(goal_idx_r) >= total_w) begin
          state_nxt = gbfs_pkg::S_FINISH;
        end else begin
          state_nxt = gbfs_pkg::S_DIVIDE;
        end
      end
      gbfs_pkg::S_DIVIDE: begin
        // start index to row and column by repeated subtraction
        if (PW'(rem_r) >= PW'(cols_c)) begin
          rem_nxt  = rem_r - IW'(cols_c);
          qrow_nxt = qrow_r + SW'(1);
        end else begin
          cell_we    = 1'b1;
          cell_waddr = start_idx_r;
          cell_wdata = '0;
          cell_wdata[gbfs_pkg::CELL_VIS] = 1'b1;
          q_we       = 1'b1;
          q_wdata    = {IW'(0), rem_r[SW-1:0], qrow_r};
          tail_nxt   = tail_r + CW'(1);
          state_nxt  = gbfs_pkg::S_POP;
        end
      end
      gbfs_pkg::S_POP: begin
        if (head_r == tail_r) begin
          state_nxt = gbfs_pkg::S_FINISH;
        end else begin
          head_nxt  = head_r + CW'(1);
          state_nxt = gbfs_pkg::S_QWAIT;
        end
      end
      gbfs_pkg::S_QWAIT: begin
        cur_row_nxt = q_q[SW-1:0];
        cur_col_nxt = q_q[2*SW-1:SW];
        dist_nxt    = CW'(q_q[gbfs_pkg::QUEUE_W-1:2*SW]) + CW'(1);
        dir_nxt     = gbfs_pkg::DIR_ROW_INC;
        state_nxt   = gbfs_pkg::S_NBR;
      end
      gbfs_pkg::S_NBR: begin
        if (nb_ok) begin
          nxt_nxt   = nb_idx_w[IW-1:0];
          nrow_nxt  = nb_row;
          ncol_nxt  = nb_col;
          state_nxt = gbfs_pkg::S_NCHK;
        end else if (dir_r == gbfs_pkg::DIR_COL_DEC) begin
          state_nxt = gbfs_pkg::S_POP;
        end else begin
          dir_nxt = gbfs_pkg::dir_t'(dir_r + 2'd1);
        end
      end
      gbfs_pkg::S_NCHK: begin
        if (CW'(nxt_r) >= load_pos_r || cell_q[gbfs_pkg::CELL_WALL]) begin
          state_nxt = gbfs_pkg::S_NBR;
        end else if (nxt_r == goal_idx_r) begin
          found_nxt = 1'b1;
          state_nxt = gbfs_pkg::S_FINISH;
        end else begin
          if (!cell_q[gbfs_pkg::CELL_VIS]) begin
            cell_we    = 1'b1;
            cell_waddr = nxt_r;
            cell_wdata = '0;
            cell_wdata[gbfs_pkg::CELL_VIS] = 1'b1;
            q_we       = 1'b1;
            q_wdata    = {dist_r[IW-1:0], ncol_r, nrow_r};
            tail_nxt   = tail_r + CW'(1);
          end
          state_nxt = gbfs_pkg::S_NBR;
        end
        if (state_nxt == gbfs_pkg::S_NBR) begin
          if (dir_r == gbfs_pkg::DIR_COL_DEC) begin
            state_nxt = gbfs_pkg::S_POP;
          end else begin
            dir_nxt = gbfs_pkg::dir_t'(dir_r + 2'd1);
          end
        end
      end
      gbfs_pkg::S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (found_r) begin
            out_data_nxt[gbfs_pkg::PATH_W-1:0] = path_sat;
            out_data_nxt[gbfs_pkg::PATH_W +: gbfs_pkg::STATUS_W] = found_stat;
          end else begin
            out_data_nxt[gbfs_pkg::PATH_W +: gbfs_pkg::STATUS_W] = gbfs_pkg::STAT_UNREACH;
          end
          load_pos_nxt = '0;
          start_v_nxt  = 1'b0;
          goal_v_nxt   = 1'b0;
          found_nxt    = 1'b0;
          state_nxt    = gbfs_pkg::S_IDLE;
        end
      end
      default: state_nxt = gbfs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= gbfs_pkg::S_IDLE;
      grid_columns_r   <= gbfs_pkg::RESET_COLUMNS;
      grid_rows_r      <= gbfs_pkg::RESET_ROWS;
      distance_limit_r <= gbfs_pkg::RESET_LIMIT;
      load_pos_r       <= '0;
      start_v_r        <= 1'b0;
      goal_v_r         <= 1'b0;
      head_r           <= '0;
      tail_r           <= '0;
      found_r          <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_pos_r  <= load_pos_nxt;
      start_v_r   <= start_v_nxt;
      goal_v_r    <= goal_v_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          gbfs_pkg::CFG_COLUMNS: grid_columns_r   <= cfg_wdata[gbfs_pkg::CFG_SIDE_W-1:0];
          gbfs_pkg::CFG_ROWS:    grid_rows_r      <= cfg_wdata[gbfs_pkg::CFG_SIDE_W-1:0];
          gbfs_pkg::CFG_LIMIT:   distance_limit_r <= cfg_wdata[gbfs_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    dir_r       <= dir_nxt;
    start_idx_r <= start_idx_nxt;
    goal_idx_r  <= goal_idx_nxt;
    rem_r       <= rem_nxt;
    qrow_r      <= qrow_nxt;
    cur_row_r   <= cur_row_nxt;
    cur_col_r   <= cur_col_nxt;
    nrow_r      <= nrow_nxt;
    ncol_r      <= ncol_nxt;
    dist_r      <= dist_nxt;
    nxt_r       <= nxt_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the grid shortest path unit: BFS predictor plus stream drivers.
`timescale 1ns / 100ps

module tb;
  import gbfs_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RST_CYCLES   = 4;
  localparam int SETTLE       = 16;
  localparam int END_WAIT     = 100;
  localparam int ITEM_TARGET  = 550;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_CELLS    = 160;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [PATH_W-1:0]   distance;
    logic [STATUS_W-1:0] status;
  } route_t;

  class route_checker;
    bit                    wall [CELL_COUNT];
    int                    load_pos;
    int                    start_pos;
    int                    goal_pos;
    bit                    start_ok;
    bit                    goal_ok;
    logic [CFG_SIDE_W-1:0] cols_reg;
    logic [CFG_SIDE_W-1:0] rows_reg;
    logic [LIMIT_W-1:0]    limit_reg;
    route_t                expected_routes[$];
    int                    errors;

    function new();
      cols_reg  = RESET_COLUMNS;
      rows_reg  = RESET_ROWS;
      limit_reg = RESET_LIMIT;
      errors    = 0;
      clear_grid();
    endfunction

    function void clear_grid();
      load_pos  = 0;
      start_pos = 0;
      goal_pos  = 0;
      start_ok  = 1'b0;
      goal_ok   = 1'b0;
    endfunction

    function int side(logic [CFG_SIDE_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return int'(v);
    endfunction

    function int grid_cells();
      return side(cols_reg) * side(rows_reg);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_COLUMNS: cols_reg = val[CFG_SIDE_W-1:0];
        CFG_ROWS:    rows_reg = val[CFG_SIDE_W-1:0];
        CFG_LIMIT:   limit_reg = val[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // steps from start to goal, -1 when unreachable
    function int shortest_steps();
      int cols, rows, head, cur, steps, r, c, nr, nc, nxt, k;
      int cell_q[$];
      int dist_q[$];
      bit seen [CELL_COUNT];
      int dr[4];
      int dc[4];
      cols = side(cols_reg);
      rows = side(rows_reg);
      dr = '{1, -1, 0, 0};
      dc = '{0, 0, 1, -1};
      if (!start_ok || !goal_ok) return -1;
      if (start_pos >= cols * rows || goal_pos >= cols * rows) return -1;
      seen[start_pos] = 1'b1;
      cell_q.push_back(start_pos);
      dist_q.push_back(0);
      head = 0;
      while (head < cell_q.size()) begin
        cur   = cell_q[head];
        steps = dist_q[head] + 1;
        r     = cur / cols;
        c     = cur % cols;
        head++;
        for (k = 0; k < 4; k++) begin
          nr = r + dr[k];
          nc = c + dc[k];
          if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
          nxt = nr * cols + nc;
          // cells not loaded in this grid act as walls
          if (nxt >= load_pos || wall[nxt]) continue;
          if (nxt == goal_pos) return steps;
          if (!seen[nxt]) begin
            seen[nxt] = 1'b1;
            cell_q.push_back(nxt);
            dist_q.push_back(steps);
          end
        end
      end
      return -1;
    endfunction

    function void load_cell(logic [KIND_W-1:0] kind, logic last);
      route_t r;
      int     d;
      if (load_pos < grid_cells()) begin
        wall[load_pos] = (kind == KIND_WALL);
        if (kind == KIND_START) begin
          start_ok  = 1'b1;
          start_pos = load_pos;
        end
        if (kind == KIND_GOAL) begin
          goal_ok  = 1'b1;
          goal_pos = load_pos;
        end
        load_pos++;
      end
      if (!last) return;
      d = shortest_steps();
      if (d < 0) begin
        r.distance = '0;
        r.status   = STAT_UNREACH;
      end else begin
        r.distance = (d > 4095) ? '1 : PATH_W'(d);
        r.status   = (d >= limit_reg) ? STAT_FAR : STAT_FOUND;
      end
      expected_routes.push_back(r);
      clear_grid();
    endfunction

    function int pending();
      return expected_routes.size();
    endfunction

    function void check_route(logic [OUT_DATA_W-1:0] data);
      route_t              want;
      logic [PATH_W-1:0]   got_d;
      logic [STATUS_W-1:0] got_s;
      got_d = data[PATH_W-1:0];
      got_s = data[PATH_W+STATUS_W-1:PATH_W];
      if (expected_routes.size() == 0) begin
        $error("unexpected item: path_distance %0d search_status %0d", got_d, got_s);
        errors++;
        return;
      end
      want = expected_routes.pop_front();
      if (got_d !== want.distance) begin
        $error("path_distance expected %0d actual %0d", want.distance, got_d);
        errors++;
      end
      if (got_s !== want.status) begin
        $error("search_status expected %0d actual %0d", want.status, got_s);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  route_checker routes;
  bit           steady = 1'b0;
  int           loaded_items = 0;

  grid_bfs_shortest_path_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic int pause();
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    routes.set_reg(idx, val);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_cell(input logic [KIND_W-1:0] kind, input logic last);
    int gap;
    gap = pause();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {{(IN_DATA_W-KIND_W){1'b0}}, kind};
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!(in_tvalid === 1'b1 && in_tready === 1'b1));
    routes.load_cell(kind, last);
  endtask

  // drop valid, wait for all routes, then let the block settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (routes.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_pattern(input string cells, input bit close);
    int               i;
    logic [KIND_W-1:0] kind;
    for (i = 0; i < cells.len(); i++) begin
      case (cells[i])
        "W":     kind = KIND_WALL;
        "S":     kind = KIND_START;
        "G":     kind = KIND_GOAL;
        default: kind = KIND_OPEN;
      endcase
      send_cell(kind, close && (i == cells.len() - 1));
    end
    wait_idle();
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_side();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CFG_DATA_W'($urandom_range(65, 127));
      2:       return CFG_DATA_W'(MAX_SIDE);
      3:       return CFG_DATA_W'($urandom_range(9, 16));
      default: return CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_W'(1);
      2:       return '1;
      3:       return CFG_DATA_W'($urandom_range(0, 8191));
      default: return CFG_DATA_W'($urandom_range(1, 20));
    endcase
  endfunction

  task automatic random_grid();
    logic [CFG_DATA_W-1:0] cols_v, rows_v;
    logic [KIND_W-1:0]     kind;
    int                    total, n, s, g, shape, wall_pct, i;
    cols_v = pick_side();
    rows_v = pick_side();
    if (routes.side(cols_v[CFG_SIDE_W-1:0]) * routes.side(rows_v[CFG_SIDE_W-1:0]) > MAX_CELLS)
      rows_v = CFG_DATA_W'($urandom_range(0, 2));
    write_reg(CFG_COLUMNS, cols_v);
    write_reg(CFG_ROWS, rows_v);
    write_reg(CFG_LIMIT, pick_limit());
    steady   = ($urandom_range(0, 3) == 0);
    total    = routes.grid_cells();
    shape    = $urandom_range(0, 9);
    wall_pct = $urandom_range(0, 35);
    case (shape)
      7:       n = $urandom_range(1, total);
      8:       n = total + $urandom_range(1, 5);
      9:       n = $urandom_range(1, total + 3);
      default: n = total;
    endcase
    s = $urandom_range(0, n - 1);
    g = $urandom_range(0, n - 1);
    for (i = 0; i < n; i++) begin
      if (shape == 9 || i >= total) kind = KIND_W'($urandom_range(0, 3));
      else if (i == g) kind = KIND_GOAL;
      else if (i == s) kind = KIND_START;
      else if ($urandom_range(0, 99) < wall_pct) kind = KIND_WALL;
      else kind = KIND_OPEN;
      send_cell(kind, i == n - 1);
      if (i < total) loaded_items++;
    end
    wait_idle();
  endtask

  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = pause();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid === 1'b1 && out_tready === 1'b1));
      routes.check_route(out_tdata);
    end
  end

  initial begin
    routes = new();
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 8191)));
    write_reg(CFG_COLUMNS, CFG_DATA_W'(3));
    write_reg(CFG_ROWS, CFG_DATA_W'(2));
    send_pattern("SWGOOO", 1'b1);
    // 1x1 grid from zero sizes, extra cells dropped
    write_reg(CFG_COLUMNS, '0);
    write_reg(CFG_ROWS, '0);
    send_pattern("GSW", 1'b1);
    // oversized columns, early last, zero limit
    write_reg(CFG_COLUMNS, CFG_DATA_W'(127));
    write_reg(CFG_ROWS, CFG_DATA_W'(1));
    write_reg(CFG_LIMIT, '0);
    send_pattern("SOG", 1'b1);
    // second start wins
    write_reg(CFG_COLUMNS, CFG_DATA_W'(2));
    write_reg(CFG_ROWS, CFG_DATA_W'(2));
    write_reg(CFG_LIMIT, '1);
    send_pattern("SGSO", 1'b1);
    // goal falls outside after rows shrink
    write_reg(CFG_ROWS, CFG_DATA_W'(3));
    write_reg(CFG_LIMIT, CFG_DATA_W'(1));
    send_pattern("SOOOG", 1'b0);
    write_reg(CFG_ROWS, CFG_DATA_W'(2));
    send_pattern("O", 1'b1);

    while (loaded_items < ITEM_TARGET) random_grid();

    steady = 1'b0;
    repeat (END_WAIT) @(posedge clk);
    if (routes.errors == 0 && routes.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("Regression FAIL");
    $finish;
  end

endmodule
